// File: rtl/lrwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrwp_pkg: shared types and constants for the least-requested window picker
// Slot counts, counter widths and the struct types used between modules.
// ----------------------------------------------------------------------------
package lrwp_pkg;

    localparam int SLOTS      = 256;
    localparam int WINDOW     = 64;
    localparam int COUNT_BITS = 16;

    localparam int WIN_EFF    = (WINDOW > SLOTS) ? SLOTS : ((WINDOW < 1) ? 1 : WINDOW);
    localparam int NWIN       = SLOTS - WIN_EFF + 1;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_BITS   = $clog2(SLOTS + 1);
    localparam int OFF_BITS   = (WIN_EFF > 1) ? $clog2(WIN_EFF) : 1;
    localparam int SUM_BITS   = COUNT_BITS + $clog2(WIN_EFF + 2);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic MODE_PICK   = 1'b0;
    localparam logic MODE_CANCEL = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] cancel_start;
        logic [8:0] cancel_size;
    } in_item_t;

    typedef struct packed {
        logic [7:0] window_start;
        logic [8:0] window_size;
        logic       picked;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SCAN,
        OP_INC,
        OP_DEC
    } op_t;

    // controller to datapath
    typedef struct packed {
        op_t                  op;
        logic                 first;     // first slot of a window, restart sum and min
        logic                 last;      // last slot of a window, score it
        logic [SLOT_BITS-1:0] idx;       // slot addressed this cycle
        logic                 idx_valid;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/lrwp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrwp_datapath: counter memory, window sum and minimum, best window
// Counters live in a memory read one slot a cycle; a scan rebuilds the sum
// and the minimum of each window from its slots and keeps the lowest score.
// ----------------------------------------------------------------------------
module lrwp_datapath
    import lrwp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output logic [SLOT_BITS-1:0]      best_start,
    output logic                      scan_done
);

    logic [COUNT_BITS-1:0] mem [SLOTS];
    logic [COUNT_BITS-1:0] rd_reg;
    logic                  rd_valid_reg;
    op_t                   rd_op_reg;
    logic                  rd_first_reg;
    logic                  rd_last_reg;
    logic [SLOT_BITS-1:0]  rd_idx_reg;

    logic [SUM_BITS-1:0]   sum_reg;
    logic [COUNT_BITS-1:0] min_reg;
    logic [SUM_BITS-1:0]   best_score_reg;
    logic [SLOT_BITS-1:0]  best_reg;
    logic                  done_reg;

    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  scan_step;
    logic [SUM_BITS-1:0]   sum_next;
    logic [COUNT_BITS-1:0] min_next;
    logic [SUM_BITS-1:0]   score;
    logic [SLOT_BITS-1:0]  win_start;
    logic                  take_best;

    // single write port: clear from the command stage, inc/dec from the read stage
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.idx;
        wr_data = '0;
        if (cmd.idx_valid && cmd.op == OP_CLEAR)
            wr_en = 1'b1;
        else if (rd_valid_reg && rd_op_reg == OP_INC && rd_reg != COUNT_MAX)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = rd_reg + COUNT_BITS'(1);
        end
        else if (rd_valid_reg && rd_op_reg == OP_DEC && rd_reg != '0)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = rd_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.idx_valid)
            rd_reg <= mem[cmd.idx];
    end

    assign scan_step = rd_valid_reg && rd_op_reg == OP_SCAN;
    assign sum_next  = (rd_first_reg ? SUM_BITS'(0) : sum_reg) + SUM_BITS'(rd_reg);
    assign min_next  = (rd_first_reg || rd_reg < min_reg) ? rd_reg : min_reg;
    assign score     = sum_next + SUM_BITS'(min_next);
    assign win_start = rd_idx_reg - SLOT_BITS'(WIN_EFF - 1);
    // window 0 is always scored first, so it seeds the best score
    assign take_best = scan_step && rd_last_reg
                       && (win_start == '0 || score < best_score_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_op_reg      <= OP_NONE;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            sum_reg        <= '0;
            min_reg        <= '0;
            best_score_reg <= '0;
            best_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.idx_valid;
            rd_op_reg    <= cmd.op;
            rd_first_reg <= cmd.first;
            rd_last_reg  <= cmd.last;
            rd_idx_reg   <= cmd.idx;
            done_reg     <= scan_step && rd_last_reg;
            if (scan_step)
            begin
                sum_reg <= sum_next;
                min_reg <= min_next;
            end
            if (take_best)
            begin
                best_score_reg <= score;
                best_reg       <= win_start;
            end
        end
    end

    assign best_start = best_reg;
    assign scan_done  = done_reg;

endmodule

`default_nettype wire

// File: rtl/lrwp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrwp_ctrl: sequencer for clear, scan, increment and cancel passes
// Steps the slot address and hands results out as one-cycle strobes.
// ----------------------------------------------------------------------------
module lrwp_ctrl
    import lrwp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire in_item_t             in_item,
    output logic                      busy,
    output logic                      done,
    output out_item_t                 result,
    output dp_cmd_t                   cmd,
    input  wire logic [SLOT_BITS-1:0] best_start,
    input  wire logic                 scan_done
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_INC   = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_BITS-1:0] base_reg, base_next;   // window start during a scan
    logic [OFF_BITS-1:0]  off_reg, off_next;     // slot within the window
    logic [IDX_BITS-1:0]  end_reg, end_next;
    logic                 pick_reg, pick_next;
    logic                 done_reg, done_next;
    out_item_t            result_reg;
    logic [10:0]          cend;

    assign cend = 11'(in_item.cancel_start) + 11'(in_item.cancel_size);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        end_next   = end_reg;
        pick_next  = pick_reg;
        done_next  = 1'b0;
        cmd        = '{op: OP_NONE, first: 1'b0, last: 1'b0, idx: idx_reg, idx_valid: 1'b0};
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                cmd.idx_valid = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_BITS'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    pick_next = (in_item.mode == MODE_PICK);
                    base_next = '0;
                    off_next  = '0;
                    if (in_item.mode == MODE_PICK)
                        state_next = S_SCAN;
                    else if (11'(in_item.cancel_start) >= 11'(SLOTS)
                             || in_item.cancel_size == '0)
                        state_next = S_DONE;
                    else
                    begin
                        idx_next   = SLOT_BITS'(in_item.cancel_start);
                        end_next   = (cend > 11'(SLOTS)) ? IDX_BITS'(SLOTS)
                                                         : IDX_BITS'(cend);
                        state_next = S_DEC;
                    end
                end
            end
            S_SCAN:
            begin
                // every window is read in full for its sum and minimum
                cmd.op        = OP_SCAN;
                cmd.idx_valid = 1'b1;
                cmd.idx       = base_reg + SLOT_BITS'(off_reg);
                cmd.first     = (off_reg == '0);
                cmd.last      = (off_reg == OFF_BITS'(WIN_EFF - 1));
                if (off_reg == OFF_BITS'(WIN_EFF - 1))
                begin
                    off_next = '0;
                    if (base_reg == SLOT_BITS'(NWIN - 1))
                        state_next = S_WAIT;
                    else
                        base_next = base_reg + 1'b1;
                end
                else
                    off_next = off_reg + 1'b1;
            end
            S_WAIT:
            begin
                // last window scored: best_start is final
                if (scan_done)
                begin
                    idx_next   = best_start;
                    end_next   = IDX_BITS'(best_start) + IDX_BITS'(WIN_EFF);
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                cmd.op = OP_INC;
                cmd.idx_valid = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (IDX_BITS'(idx_reg) + IDX_BITS'(1) == end_reg)
                    state_next = S_DONE;
            end
            S_DEC:
            begin
                cmd.op = OP_DEC;
                cmd.idx_valid = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (IDX_BITS'(idx_reg) + IDX_BITS'(1) == end_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // the last counter write lands this cycle
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            base_reg   <= '0;
            off_reg    <= '0;
            end_reg    <= '0;
            pick_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            base_reg  <= base_next;
            off_reg   <= off_next;
            end_reg   <= end_next;
            pick_reg  <= pick_next;
            done_reg  <= done_next;
            if (done_next)
            begin
                result_reg.window_start <= pick_reg ? 8'(best_start) : 8'd0;
                result_reg.window_size  <= pick_reg ? 9'(WIN_EFF) : 9'd0;
                result_reg.picked       <= pick_reg;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/least_requested_window_pick_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// least_requested_window_pick_top: least-requested window picker
// A pick reads every window in full (sum plus minimum), then bumps the chosen
// window. A cancel steps through its clamped range. busy drops with the result,
// so the next transaction is taken in that cycle. After reset a clearing pass
// over all SLOTS slots holds busy high. Results are one-cycle strobes on done;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module least_requested_window_pick_top
    import lrwp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire in_item_t  in_item,
    output logic           busy,
    output logic           done,
    output out_item_t      result
);

    dp_cmd_t              cmd;
    logic [SLOT_BITS-1:0] best_start;
    logic                 scan_done;

    lrwp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .in_item    (in_item),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .cmd        (cmd),
        .best_start (best_start),
        .scan_done  (scan_done)
    );

    lrwp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .best_start (best_start),
        .scan_done  (scan_done)
    );

endmodule

`default_nettype wire

// File: tb/least_requested_window_pick_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_requested_window_pick_top_tb: self-checking bench for the window picker
// Drives pick and cancel transactions from a directed table and then at
// random. A local model of the slot counters predicts each result the table
// does not give, and results are checked against expectations in arrival order.
// ----------------------------------------------------------------------------
module least_requested_window_pick_top_tb;
    import lrwp_pkg::*;

    localparam int   CYCLE_LIMIT = 5000000;
    localparam int   N_RANDOM    = 1080;
    localparam int   N_DIRECTED  = 16;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t exp;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  in_item;
    logic      busy;
    logic      done;
    out_item_t result;

    int        slot_count [SLOTS];
    out_item_t pending_results [$];
    stim_row_t directed [N_DIRECTED];
    int        cycles;
    bit        failed;

    least_requested_window_pick_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // advance the slot counters by one transaction, return the expected result
    function automatic out_item_t apply_to_counters(in_item_t it);
        out_item_t r;
        longint    score;
        longint    best_score;
        int        best;
        int        mn;
        int        stop;
        r = '0;
        if (it.mode == MODE_PICK) begin
            best = 0;
            best_score = -1;
            for (int s = 0; s + WIN_EFF <= SLOTS; s++) begin
                score = 0;
                mn = slot_count[s];
                for (int k = 0; k < WIN_EFF; k++) begin
                    score += slot_count[s + k];
                    if (slot_count[s + k] < mn)
                        mn = slot_count[s + k];
                end
                score += mn;
                if (best_score < 0 || score < best_score) begin
                    best_score = score;
                    best = s;
                end
            end
            for (int k = 0; k < WIN_EFF; k++)
                if (slot_count[best + k] < int'(COUNT_MAX))
                    slot_count[best + k]++;
            r.window_start = best[7:0];
            r.window_size  = 9'(WIN_EFF);
            r.picked       = 1'b1;
        end else if (it.cancel_size != 0 && int'(it.cancel_start) < SLOTS) begin
            stop = int'(it.cancel_start) + int'(it.cancel_size);
            if (stop > SLOTS)
                stop = SLOTS;
            for (int i = it.cancel_start; i < stop; i++)
                if (slot_count[i] > 0)
                    slot_count[i]--;
        end
        return r;
    endfunction

    function automatic stim_row_t make_row(logic m, int st, int sz, bit typed,
                                           int es, int ez, logic ep);
        stim_row_t row;
        row.item.mode         = m;
        row.item.cancel_start = st[7:0];
        row.item.cancel_size  = sz[8:0];
        row.typed             = typed;
        row.exp.window_start  = es[7:0];
        row.exp.window_size   = ez[8:0];
        row.exp.picked        = ep;
        return row;
    endfunction

    // hold start until the block takes the transaction
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_exp,
                             bit allow_gap);
        out_item_t predicted;
        int        gap;
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_to_counters(it);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, result);
                failed = 1'b1;
            end else begin
                out_item_t want;
                want = pending_results.pop_front();
                if (result.window_start !== want.window_start) begin
                    $display("%0t: window_start expected %0d actual %0d",
                             $time, want.window_start, result.window_start);
                    failed = 1'b1;
                end
                if (result.window_size !== want.window_size) begin
                    $display("%0t: window_size expected %0d actual %0d",
                             $time, want.window_size, result.window_size);
                    failed = 1'b1;
                end
                if (result.picked !== want.picked) begin
                    $display("%0t: picked expected %0d actual %0d",
                             $time, want.picked, result.picked);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[least_requested_window_pick_top] ERROR");
            $finish;
        end
    end

    initial begin
        in_item_t  it;
        out_item_t none;
        int        drain;
        int        sel;
        int        st;
        int        sz;
        bit        late;
        none    = '0;
        failed  = 1'b0;
        cycles  = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        in_item = '0;
        foreach (slot_count[i])
            slot_count[i] = 0;

        // fresh table: successive picks walk across untouched windows
        directed[0]  = make_row(MODE_PICK,   0,   0,   1, 0,   64, 1'b1);
        directed[1]  = make_row(MODE_PICK,   255, 511, 1, 64,  64, 1'b1);
        directed[2]  = make_row(MODE_PICK,   0,   0,   1, 128, 64, 1'b1);
        directed[3]  = make_row(MODE_PICK,   0,   0,   1, 192, 64, 1'b1);
        directed[4]  = make_row(MODE_PICK,   0,   0,   1, 0,   64, 1'b1);
        // cancels, including past the table end and zero size
        directed[5]  = make_row(MODE_CANCEL, 255, 511, 1, 0,   0,  1'b0);
        directed[6]  = make_row(MODE_CANCEL, 0,   0,   1, 0,   0,  1'b0);
        directed[7]  = make_row(MODE_CANCEL, 200, 100, 1, 0,   0,  1'b0);
        directed[8]  = make_row(MODE_CANCEL, 0,   256, 1, 0,   0,  1'b0);
        directed[9]  = make_row(MODE_CANCEL, 0,   256, 1, 0,   0,  1'b0);
        directed[10] = make_row(MODE_CANCEL, 0,   256, 1, 0,   0,  1'b0);
        directed[11] = make_row(MODE_CANCEL, 170, 1,   1, 0,   0,  1'b0);
        // counters at zero in every slot
        directed[12] = make_row(MODE_PICK,   0,   0,   0, 0,   0,  1'b0);
        directed[13] = make_row(MODE_CANCEL, 5,   3,   0, 0,   0,  1'b0);
        directed[14] = make_row(MODE_PICK,   0,   0,   0, 0,   0,  1'b0);
        directed[15] = make_row(MODE_PICK,   0,   0,   0, 0,   0,  1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].exp, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            late = (n > N_RANDOM - 150);
            it   = '0;
            sel  = $urandom_range(0, 99);
            if (sel < 6) begin
                // picks are slow; random cancel fields still ride along
                it.mode         = MODE_PICK;
                it.cancel_start = 8'($urandom);
                it.cancel_size  = 9'($urandom);
            end else begin
                it.mode = MODE_CANCEL;
                st = $urandom_range(0, 255);
                if (sel < 10)
                    sz = $urandom_range(0, 511);
                else if (sel < 14)
                    sz = 0;
                else if (sel < 18)
                    sz = $urandom_range(256, 511);
                else
                    sz = $urandom_range(1, 40);
                it.cancel_start = st[7:0];
                it.cancel_size  = sz[8:0];
            end
            send_item(it, 1'b0, none, !late);
        end
        start <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 200000) begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);

        if (!failed && pending_results.size() == 0) begin
            $display("[least_requested_window_pick_top] OK");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time,
                         pending_results.size());
            $display("[least_requested_window_pick_top] ERROR");
        end
        $finish;
    end

endmodule

// File: least_requested_window_pick_top.f
rtl/lrwp_pkg.sv
rtl/lrwp_datapath.sv
rtl/lrwp_ctrl.sv
rtl/least_requested_window_pick_top.sv
tb/least_requested_window_pick_top_tb.sv
